FILE: src/arp_cache_responder_macros.svh
// Assertion macros for the ARP cache responder; arpc_back includes them.
`ifndef ARP_CACHE_RESPONDER_MACROS_SVH
`define ARP_CACHE_RESPONDER_MACROS_SVH
`ifndef SYNTHESIS
`define ARPC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ARPC_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define ARPC_ASSERT(label, prop, msg)
`define ARPC_ASSERT_RST(label, prop, msg)
`endif
`endif

FILE: src/arpc_pkg.sv
`default_nettype none
package arpc_pkg;

  localparam int CFG_IDX_W = 8;
  localparam int CFG_DATA_W = 48;

  localparam logic [CFG_IDX_W-1:0] CFG_OWN_IP = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OWN_MAC = 8'd1;

  localparam logic [15:0] HW_ETHERNET = 16'h0001;
  localparam logic [15:0] PROTO_IPV4 = 16'h0800;
  localparam logic [15:0] OP_REQUEST = 16'h0001;
  localparam logic [31:0] OWN_IP_RESET = 32'hc0a8_00fe;

  typedef enum logic [1:0] {
    ACT_NONE,
    ACT_REFRESH,
    ACT_ADD,
    ACT_FULL
  } act_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SCAN,
    BK_LAST,
    BK_WRITE,
    BK_FINISH
  } bk_state_t;

  typedef struct packed {
    logic        foreign;
    logic        for_us;
    logic        is_request;
    logic [47:0] sender_mac;
    logic [31:0] sender_ip;
  } arpc_item_t;

endpackage
`default_nettype wire

FILE: src/arp_cache_responder.sv
`default_nettype none
// ARP responder with a small sender cache.
// Input channel (in_valid/in_ready) carries the decoded fields of one received
// ARP packet per item. Output channel (out_valid/out_ready) returns exactly one
// result item per input item, in order: reply flag, reply destination MAC and
// IP, and the cache action taken.
// The configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) is
// always ready; index 0 writes own_ip from the low 32 bits, index 1 writes
// own_mac, other indexes are ignored. Write it only while the block is idle.
// An item is classified in a front stage and passes through a two-entry queue
// to the cache engine, which reads one table entry a cycle from a
// single-port memory. The engine takes one item at a time: it scans the whole
// table for an Ethernet/IPv4 item before it takes the next, while a foreign
// item skips the scan. The table scan sets the rate.
// Reset clears all cache valid bits at once and sets own_ip to 192.168.0.254
// and own_mac to zero. When the receiver stalls, the result is held in the
// output register, the queue and the front stage fill, and then in_ready falls.
module arp_cache_responder #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [arpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [15:0]                    hardware_type,
  input  wire logic [15:0]                    protocol_type,
  input  wire logic [15:0]                    opcode,
  input  wire logic [47:0]                    sender_mac,
  input  wire logic [31:0]                    sender_ip,
  input  wire logic [31:0]                    target_ip,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic                                send_reply,
  output logic [47:0]                         reply_dst_mac,
  output logic [31:0]                         reply_dst_ip,
  output logic [1:0]                          cache_action
);
  import arpc_pkg::*;

  logic       fr_valid;
  logic       fr_ready;
  arpc_item_t fr_item;
  logic       q_valid;
  logic       q_pop;
  arpc_item_t q_item;

  arpc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .hardware_type (hardware_type),
    .protocol_type (protocol_type),
    .opcode        (opcode),
    .sender_mac    (sender_mac),
    .sender_ip     (sender_ip),
    .target_ip     (target_ip),
    .item_valid    (fr_valid),
    .item_ready    (fr_ready),
    .item          (fr_item)
  );

  arpc_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  arpc_back #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_item        (q_item),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .send_reply    (send_reply),
    .reply_dst_mac (reply_dst_mac),
    .reply_dst_ip  (reply_dst_ip),
    .cache_action  (cache_action)
  );

endmodule
`default_nettype wire

FILE: src/arpc_front.sv
`default_nettype none
module arpc_front (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [arpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [arpc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [15:0]                    hardware_type,
  input  wire logic [15:0]                    protocol_type,
  input  wire logic [15:0]                    opcode,
  input  wire logic [47:0]                    sender_mac,
  input  wire logic [31:0]                    sender_ip,
  input  wire logic [31:0]                    target_ip,
  output logic                                item_valid,
  input  wire logic                           item_ready,
  output arpc_pkg::arpc_item_t                item
);
  import arpc_pkg::*;

  logic        own_ip_en;
  logic        own_mac_en;
  logic [31:0] own_ip;
  logic [47:0] own_mac;
  logic        stage_valid;
  arpc_item_t  stage;
  arpc_item_t  stage_next;

  // The own MAC register is held here; nothing in this module reads it.
  assign cfg_ready  = 1'b1;
  assign own_ip_en  = cfg_valid && (cfg_index == CFG_OWN_IP);
  assign own_mac_en = cfg_valid && (cfg_index == CFG_OWN_MAC);

  always_ff @(posedge clk) begin
    if (rst) begin
      own_ip  <= OWN_IP_RESET;
      own_mac <= '0;
    end else begin
      if (own_ip_en) begin
        own_ip <= cfg_data[31:0];
      end
      if (own_mac_en) begin
        own_mac <= cfg_data[47:0];
      end
    end
  end

  always_comb begin
    stage_next.foreign    = !((hardware_type == HW_ETHERNET) &&
                              (protocol_type == PROTO_IPV4));
    stage_next.for_us     = (target_ip == own_ip);
    stage_next.is_request = (opcode == OP_REQUEST);
    stage_next.sender_mac = sender_mac;
    stage_next.sender_ip  = sender_ip;
  end

  assign in_ready   = !stage_valid || item_ready;
  assign item_valid = stage_valid;
  assign item       = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      stage_valid <= 1'b1;
    end else if (item_ready) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage <= stage_next;
    end
  end

endmodule
`default_nettype wire

FILE: src/arpc_queue.sv
`default_nettype none
module arpc_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire arpc_pkg::arpc_item_t push_item,
  output logic                pop_valid,
  input  wire logic           pop,
  output arpc_pkg::arpc_item_t pop_item
);
  import arpc_pkg::*;

  arpc_item_t  slot [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        do_push;
  logic        do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_item   = slot[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (do_push && !do_pop) begin
        count <= count + 2'd1;
      end else if (do_pop && !do_push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_item;
    end
  end

endmodule
`default_nettype wire

FILE: src/arpc_back.sv
`default_nettype none
`include "arp_cache_responder_macros.svh"
module arpc_back #(
  parameter int TABLE_ENTRIES = 16
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire arpc_pkg::arpc_item_t q_item,
  output logic                q_pop,
  output logic                out_valid,
  input  wire logic           out_ready,
  output logic                send_reply,
  output logic [47:0]         reply_dst_mac,
  output logic [31:0]         reply_dst_ip,
  output logic [1:0]          cache_action
);
  import arpc_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);

  bk_state_t                state;
  bk_state_t                state_next;
  logic [IW-1:0]            scan_idx;
  logic [IW-1:0]            cmp_idx;
  logic                     cmp_vld;
  logic [31:0]              rd_ip;
  logic                     hit_found;
  logic [IW-1:0]            hit_idx;
  logic                     free_found;
  logic [IW-1:0]            free_idx;
  logic [TABLE_ENTRIES-1:0] valid;
  logic [31:0]              entry_ip [TABLE_ENTRIES];
  logic [47:0]              entry_mac [TABLE_ENTRIES];
  act_t                     act;
  act_t                     act_calc;
  logic                     ip_we;
  logic                     mac_we;
  logic [IW-1:0]            wr_idx;
  logic                     out_load;
  logic                     reply_next;

  assign out_load   = !out_valid || out_ready;
  assign reply_next = !q_item.foreign && q_item.for_us && q_item.is_request;

  always_comb begin
    if (hit_found) begin
      act_calc = ACT_REFRESH;
    end else if (q_item.for_us) begin
      act_calc = free_found ? ACT_ADD : ACT_FULL;
    end else begin
      act_calc = ACT_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    ip_we      = 1'b0;
    mac_we     = 1'b0;
    wr_idx     = hit_found ? hit_idx : free_idx;
    case (state)
      BK_IDLE: begin
        if (q_valid) begin
          state_next = q_item.foreign ? BK_FINISH : BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_idx == LAST_IDX) begin
          state_next = BK_LAST;
        end
      end
      BK_LAST: begin
        state_next = BK_WRITE;
      end
      BK_WRITE: begin
        mac_we     = (act_calc == ACT_REFRESH) || (act_calc == ACT_ADD);
        ip_we      = (act_calc == ACT_ADD);
        state_next = BK_FINISH;
      end
      BK_FINISH: begin
        if (out_load) begin
          q_pop      = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: begin
        state_next = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx   <= '0;
      cmp_vld    <= 1'b0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      valid      <= '0;
      act        <= ACT_NONE;
    end else begin
      cmp_vld <= (state == BK_SCAN);
      if (state == BK_IDLE) begin
        scan_idx   <= '0;
        hit_found  <= 1'b0;
        free_found <= 1'b0;
        act        <= ACT_NONE;
      end else if ((state == BK_SCAN) && (scan_idx != LAST_IDX)) begin
        scan_idx <= scan_idx + IW'(1);
      end
      if (cmp_vld) begin
        if (valid[cmp_idx] && (rd_ip == q_item.sender_ip) && !hit_found) begin
          hit_found <= 1'b1;
        end
        if (!valid[cmp_idx] && !free_found) begin
          free_found <= 1'b1;
        end
      end
      if (state == BK_WRITE) begin
        act <= act_calc;
      end
      if (ip_we) begin
        valid[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    cmp_idx <= scan_idx;
    if (cmp_vld && valid[cmp_idx] && (rd_ip == q_item.sender_ip) && !hit_found) begin
      hit_idx <= cmp_idx;
    end
    if (cmp_vld && !valid[cmp_idx] && !free_found) begin
      free_idx <= cmp_idx;
    end
  end

  always_ff @(posedge clk) begin
    rd_ip <= entry_ip[scan_idx];
    if (ip_we) begin
      entry_ip[wr_idx] <= q_item.sender_ip;
    end
    if (mac_we) begin
      entry_mac[wr_idx] <= q_item.sender_mac;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (q_pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      send_reply    <= reply_next;
      reply_dst_mac <= reply_next ? q_item.sender_mac : 48'd0;
      reply_dst_ip  <= reply_next ? q_item.sender_ip : 32'd0;
      cache_action  <= act;
    end
  end

  `ARPC_ASSERT(a_write_in_write_state, (ip_we || mac_we) |-> (state == BK_WRITE), "table write outside the update step")
  `ARPC_ASSERT(a_add_sets_one_valid, ip_we |=> ($countones(valid) == $past($countones(valid)) + 1), "an added entry did not set exactly one valid bit")
  `ARPC_ASSERT(a_pop_needs_item, q_pop |-> q_valid, "queue popped while empty")
  `ARPC_ASSERT_RST(a_valid_clear_after_reset, $past(rst) |-> (valid == '0), "cache valid bits not cleared by reset")

endmodule
`default_nettype wire

FILE: tb/arp_cache_responder_tb.sv
`default_nettype none
module arp_cache_responder_tb;
  import arpc_pkg::*;

  localparam int TABLE_ENTRIES = 16;
  localparam int MAX_GAP = 5;
  localparam int HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 256;
  localparam int SETTLE_CYCLES = TABLE_ENTRIES + 10;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 8'hff;
  localparam logic [15:0] OP_REPLY = 16'h0002;
  localparam logic [15:0] PROTO_IPV6 = 16'h86dd;

  typedef struct {
    logic [15:0] hw;
    logic [15:0] proto;
    logic [15:0] op;
    logic [47:0] smac;
    logic [31:0] sip;
    logic [31:0] tip;
  } arp_packet_t;

  typedef struct {
    logic        send;
    logic [47:0] mac;
    logic [31:0] ip;
    act_t        action;
  } arp_reply_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [15:0] hardware_type;
  logic [15:0] protocol_type;
  logic [15:0] opcode;
  logic [47:0] sender_mac;
  logic [31:0] sender_ip;
  logic [31:0] target_ip;
  logic out_valid;
  logic out_ready;
  logic send_reply;
  logic [47:0] reply_dst_mac;
  logic [31:0] reply_dst_ip;
  logic [1:0] cache_action;

  logic [31:0] own_ip;
  logic [47:0] own_mac;
  logic        cache_valid [TABLE_ENTRIES];
  logic [31:0] cache_ip [TABLE_ENTRIES];
  logic [47:0] cache_mac [TABLE_ENTRIES];

  arp_reply_t reply_queue [$];
  int error_count = 0;
  bit tx_steady = 1'b0;
  bit rx_steady = 1'b0;
  bit hold_results = 1'b0;

  arp_cache_responder #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .hardware_type(hardware_type),
    .protocol_type(protocol_type),
    .opcode(opcode),
    .sender_mac(sender_mac),
    .sender_ip(sender_ip),
    .target_ip(target_ip),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .send_reply(send_reply),
    .reply_dst_mac(reply_dst_mac),
    .reply_dst_ip(reply_dst_ip),
    .cache_action(cache_action)
  );

  always #10 clk = ~clk;

  function automatic arp_packet_t arp_packet(logic [15:0] hw, logic [15:0] proto,
                                             logic [15:0] op, logic [47:0] smac,
                                             logic [31:0] sip, logic [31:0] tip);
    arp_packet_t p;
    p.hw = hw;
    p.proto = proto;
    p.op = op;
    p.smac = smac;
    p.sip = sip;
    p.tip = tip;
    return p;
  endfunction

  function automatic logic [47:0] random_mac();
    return {16'($urandom), 32'($urandom)};
  endfunction

  function automatic logic [31:0] fresh_ip();
    logic [31:0] ip;
    bit taken;
    do begin
      ip = $urandom;
      taken = 1'b0;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (cache_valid[i] && cache_ip[i] == ip) begin
          taken = 1'b1;
        end
      end
    end while (taken);
    return ip;
  endfunction

  function automatic arp_packet_t random_packet();
    arp_packet_t p;
    int pick;
    int slot;
    p.hw = ($urandom_range(0, 9) == 0) ? 16'($urandom) : HW_ETHERNET;
    p.proto = ($urandom_range(0, 9) == 0) ? 16'($urandom) : PROTO_IPV4;
    pick = $urandom_range(0, 3);
    p.op = (pick < 2) ? OP_REQUEST : (pick == 2) ? OP_REPLY : 16'($urandom);
    p.smac = random_mac();
    slot = $urandom_range(0, TABLE_ENTRIES - 1);
    if ($urandom_range(0, 4) != 0 && cache_valid[slot]) begin
      p.sip = cache_ip[slot];
    end else begin
      p.sip = $urandom;
    end
    p.tip = ($urandom_range(0, 1) == 0) ? own_ip : 32'($urandom);
    return p;
  endfunction

  // Updates the cache copy for one accepted packet and queues the result it should give.
  task automatic record_packet(input arp_packet_t p);
    arp_reply_t r;
    int hit;
    int slot;
    r.send = 1'b0;
    r.mac = '0;
    r.ip = '0;
    r.action = ACT_NONE;
    if (p.hw == HW_ETHERNET && p.proto == PROTO_IPV4) begin
      hit = -1;
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        if (hit < 0 && cache_valid[i] && cache_ip[i] == p.sip) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        cache_mac[hit] = p.smac;
        r.action = ACT_REFRESH;
      end
      if (p.tip == own_ip) begin
        if (hit < 0) begin
          slot = -1;
          for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (slot < 0 && !cache_valid[i]) begin
              slot = i;
            end
          end
          if (slot >= 0) begin
            cache_valid[slot] = 1'b1;
            cache_ip[slot] = p.sip;
            cache_mac[slot] = p.smac;
            r.action = ACT_ADD;
          end else begin
            r.action = ACT_FULL;
          end
        end
        if (p.op == OP_REQUEST) begin
          r.send = 1'b1;
          r.mac = p.smac;
          r.ip = p.sip;
        end
      end
    end
    reply_queue.push_back(r);
  endtask

  task automatic send_packet(input arp_packet_t p);
    int gap;
    gap = tx_steady ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    hardware_type <= p.hw;
    protocol_type <= p.proto;
    opcode <= p.op;
    sender_mac <= p.smac;
    sender_ip <= p.sip;
    target_ip <= p.tip;
    do @(posedge clk); while (!in_ready);
    record_packet(p);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_OWN_IP: own_ip = data[31:0];
      CFG_OWN_MAC: own_mac = data;
      default: ;
    endcase
  endtask

  task automatic set_addresses(input logic [31:0] ip, input logic [47:0] mac);
    write_reg(CFG_OWN_IP, {16'h0000, ip});
    write_reg(CFG_OWN_MAC, mac);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_until_idle();
    in_valid <= 1'b0;
    while (reply_queue.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic check_reply();
    arp_reply_t want;
    if (reply_queue.size() == 0) begin
      $error("unexpected result: send_reply %0d, reply_dst_mac %h, reply_dst_ip %h, cache_action %0d",
             send_reply, reply_dst_mac, reply_dst_ip, cache_action);
      error_count++;
    end else begin
      want = reply_queue.pop_front();
      if (send_reply !== want.send) begin
        $error("send_reply: expected %0d, actual %0d", want.send, send_reply);
        error_count++;
      end
      if (reply_dst_mac !== want.mac) begin
        $error("reply_dst_mac: expected %h, actual %h", want.mac, reply_dst_mac);
        error_count++;
      end
      if (reply_dst_ip !== want.ip) begin
        $error("reply_dst_ip: expected %h, actual %h", want.ip, reply_dst_ip);
        error_count++;
      end
      if (cache_action !== want.action) begin
        $error("cache_action: expected %0d, actual %0d", want.action, cache_action);
        error_count++;
      end
    end
  endtask

  task automatic test_config_writes();
    write_reg(CFG_SPARE, random_mac());
    write_reg(CFG_OWN_IP, {16'hffff, OWN_IP_RESET});
    write_reg(CFG_OWN_MAC, 48'hffff_ffff_ffff);
    cfg_valid <= 1'b0;
  endtask

  task automatic test_foreign_packets();
    send_packet(arp_packet(16'h0002, PROTO_IPV4, OP_REQUEST, random_mac(), fresh_ip(), own_ip));
    send_packet(arp_packet(HW_ETHERNET, PROTO_IPV6, OP_REQUEST, random_mac(), fresh_ip(), own_ip));
    send_packet(arp_packet(16'hffff, 16'hffff, OP_REQUEST, random_mac(), fresh_ip(), own_ip));
    send_packet(arp_packet(16'h0000, 16'h0000, OP_REQUEST, random_mac(), fresh_ip(), own_ip));
  endtask

  task automatic test_requests_add();
    send_packet(arp_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, 48'hffff_ffff_ffff,
                           32'hffff_ffff, own_ip));
    send_packet(arp_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, 48'h0, 32'h0, own_ip));
    send_packet(arp_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, random_mac(), fresh_ip(), own_ip));
  endtask

  task automatic test_other_opcodes();
    send_packet(arp_packet(HW_ETHERNET, PROTO_IPV4, OP_REPLY, random_mac(), fresh_ip(), own_ip));
    send_packet(arp_packet(HW_ETHERNET, PROTO_IPV4, 16'hffff, random_mac(), fresh_ip(), own_ip));
    send_packet(arp_packet(HW_ETHERNET, PROTO_IPV4, 16'h0000, random_mac(), fresh_ip(), own_ip));
  endtask

  task automatic test_refresh();
    send_packet(arp_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, random_mac(), cache_ip[0], own_ip));
    send_packet(arp_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, random_mac(), cache_ip[1],
                           own_ip + 32'd1));
    // A foreign packet from a cached sender must leave the entry alone.
    send_packet(arp_packet(16'h0006, PROTO_IPV4, OP_REQUEST, random_mac(), cache_ip[2], own_ip));
  endtask

  task automatic test_not_for_us();
    send_packet(arp_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, random_mac(), fresh_ip(),
                           ~own_ip));
  endtask

  task automatic test_table_full();
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (!cache_valid[i]) begin
        send_packet(arp_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, random_mac(), fresh_ip(),
                               own_ip));
      end
    end
    send_packet(arp_packet(HW_ETHERNET, PROTO_IPV4, OP_REQUEST, random_mac(), fresh_ip(), own_ip));
    send_packet(arp_packet(HW_ETHERNET, PROTO_IPV4, OP_REPLY, random_mac(), fresh_ip(), own_ip));
  endtask

  task automatic test_backpressure();
    hold_results = 1'b1;
    tx_steady = 1'b1;
    repeat (12) send_packet(random_packet());
    tx_steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    for (int phase = 0; phase < 5; phase++) begin
      wait_until_idle();
      case (phase)
        0: set_addresses(32'h0000_0000, 48'hffff_ffff_ffff);
        1: set_addresses(32'hffff_ffff, random_mac());
        2: set_addresses($urandom, 48'h0);
        3: set_addresses($urandom, random_mac());
        default: set_addresses(OWN_IP_RESET, random_mac());
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 32 == 0) begin
          tx_steady = ($urandom_range(0, 3) == 0);
          rx_steady = ($urandom_range(0, 3) == 0);
        end
        send_packet(random_packet());
      end
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  initial begin
    rst <= 1'b1;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    hardware_type <= '0;
    protocol_type <= '0;
    opcode <= '0;
    sender_mac <= '0;
    sender_ip <= '0;
    target_ip <= '0;
    own_ip = OWN_IP_RESET;
    own_mac = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      cache_valid[i] = 1'b0;
      cache_ip[i] = '0;
      cache_mac[i] = '0;
    end
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_config_writes();
    test_foreign_packets();
    test_requests_add();
    test_other_opcodes();
    test_refresh();
    test_not_for_us();
    test_table_full();
    test_backpressure();
    test_random_traffic();
    wait_until_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0 && reply_queue.size() == 0) begin
      $display("arp_cache_responder_tb passed");
    end else begin
      $display("arp_cache_responder_tb failed");
    end
    $finish;
  end

  initial begin
    int stall;
    out_ready <= 1'b0;
    @(posedge clk);
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_results) begin
        stall = HOLD_CYCLES;
        hold_results = 1'b0;
      end else if (rx_steady) begin
        stall = 0;
      end else begin
        stall = $urandom_range(0, MAX_GAP);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      check_reply();
    end
  end

  initial begin
    #(20 * 1_000_000);
    $display("arp_cache_responder_tb failed");
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
+incdir+src
src/arpc_pkg.sv
src/arpc_front.sv
src/arpc_queue.sv
src/arpc_back.sv
src/arp_cache_responder.sv
tb/arp_cache_responder_tb.sv
